// ----- rtl/gpioed_pkg.sv -----
// Shared types and register map constants for the GPIO controller with edge detection.
package gpioed_pkg;

  // Widest pin count the register map can address
  localparam int MAX_PINS = 64;
  localparam int WORD_W   = 32;

  // Item kinds
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Register word numbers
  localparam logic [4:0] IDX_FSEL0     = 5'd0;
  localparam logic [4:0] IDX_FSEL_LAST = 5'd5;
  localparam logic [4:0] IDX_SET0      = 5'd6;
  localparam logic [4:0] IDX_SET1      = 5'd7;
  localparam logic [4:0] IDX_CLR0      = 5'd8;
  localparam logic [4:0] IDX_CLR1      = 5'd9;
  localparam logic [4:0] IDX_LEV0      = 5'd10;
  localparam logic [4:0] IDX_LEV1      = 5'd11;
  localparam logic [4:0] IDX_EDS0      = 5'd12;
  localparam logic [4:0] IDX_EDS1      = 5'd13;
  localparam logic [4:0] IDX_REN0      = 5'd14;
  localparam logic [4:0] IDX_REN1      = 5'd15;
  localparam logic [4:0] IDX_FEN0      = 5'd16;
  localparam logic [4:0] IDX_FEN1      = 5'd17;
  localparam logic [4:0] IDX_PULL0     = 5'd18;
  localparam logic [4:0] IDX_PULL_LAST = 5'd21;

  // Field word layout
  localparam int FSEL_WORDS    = 6;
  localparam int FSEL_PER_WORD = 10;
  localparam int FSEL_BITS     = 3;
  localparam int FSEL_W        = FSEL_PER_WORD * FSEL_BITS;
  localparam int PULL_WORDS    = 4;
  localparam int PULL_PER_WORD = 16;
  localparam int PULL_BITS     = 2;

  // Function select code that drives the pin
  localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [4:0]        reg_index;
    logic [WORD_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              event_pending;
  } rsp_t;

endpackage

// ----- rtl/gpioed_in_stage.sv -----
// Input register stage: holds one accepted item until the core consumes it.
module gpioed_in_stage #(
  parameter int NUM_PINS = 58
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gpioed_pkg::req_t     req_i,
  input  logic [NUM_PINS-1:0]  pin_levels_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output gpioed_pkg::req_t     req_o,
  output logic [NUM_PINS-1:0]  pin_levels_o
);

  logic                valid_q, valid_d;
  logic                load;
  gpioed_pkg::req_t    req_q;
  logic [NUM_PINS-1:0] lev_q;

  // Take a new transfer when empty or when the held item moves on
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
      lev_q <= pin_levels_i;
    end
  end

  assign valid_o      = valid_q;
  assign req_o        = req_q;
  assign pin_levels_o = lev_q;

endmodule

// ----- rtl/gpioed_core.sv -----
// Register file, pin state and edge detection; computes the result of one item.
module gpioed_core #(
  parameter int NUM_PINS = 58
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  gpioed_pkg::req_t    req_i,
  input  logic [NUM_PINS-1:0] pin_levels_i,
  output gpioed_pkg::rsp_t    rsp_o,
  output logic [NUM_PINS-1:0] drive_level_o,
  output logic [NUM_PINS-1:0] drive_enable_o
);

  localparam int FSW = gpioed_pkg::FSEL_W;
  localparam int WW  = gpioed_pkg::WORD_W;
  localparam int MP  = gpioed_pkg::MAX_PINS;

  logic [FSW-1:0]      fsel_q [gpioed_pkg::FSEL_WORDS];
  logic [FSW-1:0]      fsel_d [gpioed_pkg::FSEL_WORDS];
  logic [WW-1:0]       pull_q [gpioed_pkg::PULL_WORDS];
  logic [WW-1:0]       pull_d [gpioed_pkg::PULL_WORDS];
  logic [NUM_PINS-1:0] latch_q, latch_d;
  logic [NUM_PINS-1:0] level_q, level_d;
  logic [NUM_PINS-1:0] eds_q, eds_d;
  logic [NUM_PINS-1:0] ren_q, ren_d;
  logic [NUM_PINS-1:0] fen_q, fen_d;

  logic [FSW-1:0]      fsel_mask [gpioed_pkg::FSEL_WORDS];
  logic [WW-1:0]       pull_mask [gpioed_pkg::PULL_WORDS];
  logic [2:0]          fsel_word;
  logic [1:0]          pull_word;
  logic                half;
  logic [WW-1:0]       rd;

  // Bits of a field word that belong to existing pins
  function automatic logic [WW-1:0] field_mask(int word, int bits, int per);
    logic [WW-1:0] m;
    m = '0;
    for (int k = 0; k < per; k++) begin
      if (word * per + k < NUM_PINS) begin
        for (int b = 0; b < bits; b++) begin
          m[k * bits + b] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // One 32-bit half of a pin vector
  function automatic logic [WW-1:0] get_half(logic [NUM_PINS-1:0] v, logic h);
    logic [MP-1:0] r;
    r = '0;
    r[NUM_PINS-1:0] = v;
    return h ? r[MP-1:WW] : r[WW-1:0];
  endfunction

  // Place a word on one half of a pin vector, dropping absent pins
  function automatic logic [NUM_PINS-1:0] put_half(logic [WW-1:0] w, logic h);
    logic [MP-1:0] r;
    r = h ? {w, {WW{1'b0}}} : {{WW{1'b0}}, w};
    return r[NUM_PINS-1:0];
  endfunction

  for (genvar w = 0; w < gpioed_pkg::FSEL_WORDS; w++) begin : g_fmask
    assign fsel_mask[w] = FSW'(field_mask(w, gpioed_pkg::FSEL_BITS,
                                          gpioed_pkg::FSEL_PER_WORD));
  end
  for (genvar w = 0; w < gpioed_pkg::PULL_WORDS; w++) begin : g_pmask
    assign pull_mask[w] = field_mask(w, gpioed_pkg::PULL_BITS, gpioed_pkg::PULL_PER_WORD);
  end

  assign fsel_word = req_i.reg_index[2:0];
  assign pull_word = 2'(req_i.reg_index - gpioed_pkg::IDX_PULL0);
  assign half      = req_i.reg_index[0];

  // Decode the item and form next state and read data
  always_comb begin
    fsel_d  = fsel_q;
    pull_d  = pull_q;
    latch_d = latch_q;
    level_d = level_q;
    eds_d   = eds_q;
    ren_d   = ren_q;
    fen_d   = fen_q;
    rd      = '0;
    case (req_i.mode)
      gpioed_pkg::MODE_READ: begin
        case (req_i.reg_index) inside
          [gpioed_pkg::IDX_FSEL0:gpioed_pkg::IDX_FSEL_LAST]:
            rd = WW'(fsel_q[fsel_word]);
          [gpioed_pkg::IDX_LEV0:gpioed_pkg::IDX_LEV1]: rd = get_half(level_q, half);
          [gpioed_pkg::IDX_EDS0:gpioed_pkg::IDX_EDS1]: rd = get_half(eds_q, half);
          [gpioed_pkg::IDX_REN0:gpioed_pkg::IDX_REN1]: rd = get_half(ren_q, half);
          [gpioed_pkg::IDX_FEN0:gpioed_pkg::IDX_FEN1]: rd = get_half(fen_q, half);
          [gpioed_pkg::IDX_PULL0:gpioed_pkg::IDX_PULL_LAST]: rd = pull_q[pull_word];
          default: rd = '0;
        endcase
      end
      gpioed_pkg::MODE_WRITE: begin
        case (req_i.reg_index) inside
          [gpioed_pkg::IDX_FSEL0:gpioed_pkg::IDX_FSEL_LAST]:
            fsel_d[fsel_word] = req_i.write_data[FSW-1:0] & fsel_mask[fsel_word];
          [gpioed_pkg::IDX_SET0:gpioed_pkg::IDX_SET1]:
            latch_d = latch_q | put_half(req_i.write_data, half);
          [gpioed_pkg::IDX_CLR0:gpioed_pkg::IDX_CLR1]:
            latch_d = latch_q & ~put_half(req_i.write_data, half);
          [gpioed_pkg::IDX_EDS0:gpioed_pkg::IDX_EDS1]:
            eds_d = eds_q & ~put_half(req_i.write_data, half);
          [gpioed_pkg::IDX_REN0:gpioed_pkg::IDX_REN1]:
            ren_d = (ren_q & ~put_half({WW{1'b1}}, half)) | put_half(req_i.write_data, half);
          [gpioed_pkg::IDX_FEN0:gpioed_pkg::IDX_FEN1]:
            fen_d = (fen_q & ~put_half({WW{1'b1}}, half)) | put_half(req_i.write_data, half);
          [gpioed_pkg::IDX_PULL0:gpioed_pkg::IDX_PULL_LAST]:
            pull_d[pull_word] = req_i.write_data & pull_mask[pull_word];
          default: ;
        endcase
      end
      gpioed_pkg::MODE_SAMPLE: begin
        // Record enabled edges against the previous sample
        eds_d   = eds_q | (~level_q & pin_levels_i & ren_q)
                        | (level_q & ~pin_levels_i & fen_q);
        level_d = pin_levels_i;
      end
      default: ;
    endcase
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < gpioed_pkg::FSEL_WORDS; w++) fsel_q[w] <= '0;
      for (int w = 0; w < gpioed_pkg::PULL_WORDS; w++) pull_q[w] <= '0;
      latch_q <= '0;
      level_q <= '0;
      eds_q   <= '0;
      ren_q   <= '0;
      fen_q   <= '0;
    end else if (fire_i) begin
      fsel_q  <= fsel_d;
      pull_q  <= pull_d;
      latch_q <= latch_d;
      level_q <= level_d;
      eds_q   <= eds_d;
      ren_q   <= ren_d;
      fen_q   <= fen_d;
    end
  end

  // Output enables from the updated function selects
  for (genvar i = 0; i < NUM_PINS; i++) begin : g_en
    if (i < gpioed_pkg::FSEL_WORDS * gpioed_pkg::FSEL_PER_WORD) begin : g_map
      assign drive_enable_o[i] =
        fsel_d[i / gpioed_pkg::FSEL_PER_WORD]
              [gpioed_pkg::FSEL_BITS * (i % gpioed_pkg::FSEL_PER_WORD) +: gpioed_pkg::FSEL_BITS]
        == gpioed_pkg::FSEL_OUTPUT;
    end else begin : g_nomap
      assign drive_enable_o[i] = 1'b0;
    end
  end

  assign drive_level_o       = latch_d;
  assign rsp_o.read_data     = rd;
  assign rsp_o.event_pending = |eds_d;

endmodule

// ----- rtl/gpioed_out_stage.sv -----
// Result register: holds one result until the consumer takes the transfer.
module gpioed_out_stage #(
  parameter int NUM_PINS = 58
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  output logic                can_load_o,
  input  gpioed_pkg::rsp_t    rsp_i,
  input  logic [NUM_PINS-1:0] drive_level_i,
  input  logic [NUM_PINS-1:0] drive_enable_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gpioed_pkg::rsp_t    rsp_o,
  output logic [NUM_PINS-1:0] drive_level_o,
  output logic [NUM_PINS-1:0] drive_enable_o
);

  logic                valid_q, valid_d;
  gpioed_pkg::rsp_t    rsp_q;
  logic [NUM_PINS-1:0] lvl_q;
  logic [NUM_PINS-1:0] en_q;

  // Free when empty or when the held result leaves this cycle
  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
      lvl_q <= drive_level_i;
      en_q  <= drive_enable_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign rsp_o          = rsp_q;
  assign drive_level_o  = lvl_q;
  assign drive_enable_o = en_q;

endmodule

// ----- rtl/gpio_controller_edge_detect.sv -----
// GPIO controller top level: input register, register file with edge detect, result register.
// Each item passes the input register, then the result register; pin state updates when
// the item is loaded there. Throughput: one item per cycle while out_ready_i is high.
// The result register frees in the cycle its transfer completes, so stalls cost no bubble.
// Reset clears all function selects, pulls, latches, levels, events and edge enables.
module gpio_controller_edge_detect #(
  parameter int NUM_PINS = 58
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [4:0]          reg_index_i,
  input  logic [31:0]         write_data_i,
  input  logic [NUM_PINS-1:0] pin_levels_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         read_data_o,
  output logic [NUM_PINS-1:0] drive_level_o,
  output logic [NUM_PINS-1:0] drive_enable_o,
  output logic                event_pending_o
);

  gpioed_pkg::req_t    req_in, req_s;
  gpioed_pkg::rsp_t    rsp_c, rsp_s;
  logic [NUM_PINS-1:0] lev_s;
  logic [NUM_PINS-1:0] lvl_c, en_c;
  logic                stage_valid;
  logic                can_load;
  logic                advance;

  assign req_in.mode       = mode_i;
  assign req_in.reg_index  = reg_index_i;
  assign req_in.write_data = write_data_i;

  // Move the held item forward when the result register has room
  assign advance = stage_valid && can_load;

  gpioed_in_stage #(.NUM_PINS(NUM_PINS)) u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_i        (req_in),
    .pin_levels_i (pin_levels_i),
    .advance_i    (advance),
    .valid_o      (stage_valid),
    .req_o        (req_s),
    .pin_levels_o (lev_s)
  );

  gpioed_core #(.NUM_PINS(NUM_PINS)) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .req_i          (req_s),
    .pin_levels_i   (lev_s),
    .rsp_o          (rsp_c),
    .drive_level_o  (lvl_c),
    .drive_enable_o (en_c)
  );

  gpioed_out_stage #(.NUM_PINS(NUM_PINS)) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance),
    .can_load_o     (can_load),
    .rsp_i          (rsp_c),
    .drive_level_i  (lvl_c),
    .drive_enable_i (en_c),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rsp_o          (rsp_s),
    .drive_level_o  (drive_level_o),
    .drive_enable_o (drive_enable_o)
  );

  assign read_data_o     = rsp_s.read_data;
  assign event_pending_o = rsp_s.event_pending;

endmodule
